// File: hw/rtl/tpad_pkg.sv
// ----------------------------------------------------------------------------
// tpad_pkg: shared definitions for the TRIAC phase-angle dimmer
// Counter widths, register indexes, reset values and the divide constant.
// ----------------------------------------------------------------------------
`default_nettype none

package tpad_pkg;

	localparam int COUNT_BITS  = 20;
	localparam int OFFSET_BITS = COUNT_BITS - 1;
	localparam int PROD_BITS   = 23;  // (100 - b) * half + 99 stays below 2^23
	localparam int QUOT_BITS   = 16;
	localparam int RECIP_BITS  = 31;
	localparam int RECIP_SHIFT = 37;

	// floor(x / 100) == (x * RECIP) >> 37 for every x below 2^32
	localparam logic [RECIP_BITS-1:0] RECIP = 31'd1374389535;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [6:0]  BRIGHT_FULL = 7'd100;
	localparam logic [15:0] HALF_RESET  = 16'd8333;
	localparam logic [9:0]  PULSE_RESET = 10'd100;
	localparam logic [6:0]  CEIL_BIAS   = 7'd99;

	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_HALF       = 2'd1;
	localparam logic [1:0] REG_PULSE      = 2'd2;

	// (100 - 0) * 8333 + 99
	localparam logic [PROD_BITS-1:0] PROD_RESET = 23'd833399;

	typedef struct packed {
		logic gate_drive;
		logic trigger_armed;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpad_delay.sv
// ----------------------------------------------------------------------------
// tpad_delay: firing delay from the scaled half period and crossing offset
// Divide the biased product by 100, add the offset and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tpad_delay
	import tpad_pkg::*;
(
	input  wire logic [PROD_BITS-1:0]   prod,
	input  wire logic [OFFSET_BITS-1:0] offset,
	output logic      [COUNT_BITS-1:0]  delay
);

	logic [PROD_BITS+RECIP_BITS-1:0] scaled;
	logic [QUOT_BITS-1:0]            quot;
	logic [COUNT_BITS:0]             sum;

	always_comb begin
		scaled = {{RECIP_BITS{1'b0}}, prod} * {{PROD_BITS{1'b0}}, RECIP};
		quot   = scaled[RECIP_SHIFT+QUOT_BITS-1:RECIP_SHIFT];
		sum    = (COUNT_BITS+1)'(quot) + (COUNT_BITS+1)'(offset);
		// clamp at the counter ceiling
		if (sum > (COUNT_BITS+1)'(COUNT_MAX)) begin
			delay = COUNT_MAX;
		end else begin
			delay = sum[COUNT_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/triac_phase_angle_dimmer.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_dimmer: TRIAC phase-angle control with zero-cross timing
// One input transaction per microsecond tick; one result transaction per tick.
// ----------------------------------------------------------------------------
// Each result is registered into the result buffer when its tick transaction is taken.
// Throughput: one tick per cycle while the result buffer is not full; the tick
// update is a single pass through the edge logic, the divide-by-100 multiplier and
// the trigger compare. A two-entry result buffer keeps input open while one result waits.
// Reset (arst_n low, asynchronous): all tick state cleared, registers back
// to brightness 0, half period 8333, pulse 100; no clearing pass.
`default_nettype none

module triac_phase_angle_dimmer
	import tpad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	// tick input; s_tdata: [0] zero_cross_level, [7:1] zero
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	// result output; m_tdata: [0] gate_drive, [1] trigger_armed, [7:2] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata
);

	// Configuration registers; the scaled half period is rebuilt on each brightness
	// or half-period write so the tick path only has to divide it.
	logic [6:0]           brightness_q;
	logic [15:0]          half_q;
	logic [9:0]           pulse_q;
	logic [PROD_BITS-1:0] prod_q;

	logic [6:0]           bright_clamp;
	logic [6:0]           bright_new;
	logic [6:0]           span_src;
	logic [15:0]          half_src;
	logic [PROD_BITS-1:0] prod_new;

	always_comb begin
		bright_clamp = (brightness_q > BRIGHT_FULL) ? BRIGHT_FULL : brightness_q;
		bright_new   = (cfg_wdata[6:0] > BRIGHT_FULL) ? BRIGHT_FULL : cfg_wdata[6:0];
		// pick the operands: the one being written, the stored other one
		if (cfg_index == REG_BRIGHTNESS) begin
			span_src = BRIGHT_FULL - bright_new;
			half_src = half_q;
		end else begin
			span_src = BRIGHT_FULL - bright_clamp;
			half_src = cfg_wdata;
		end
		prod_new = PROD_BITS'(span_src) * PROD_BITS'(half_src) + PROD_BITS'(CEIL_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
			half_q       <= HALF_RESET;
			pulse_q      <= PULSE_RESET;
			prod_q       <= PROD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: begin
					brightness_q <= cfg_wdata[6:0];
					prod_q       <= prod_new;
				end
				REG_HALF: begin
					half_q <= cfg_wdata;
					prod_q <= prod_new;
				end
				REG_PULSE: begin
					pulse_q <= cfg_wdata[9:0];
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Tick state
	logic                   seen_high_q;
	logic [COUNT_BITS-1:0]  elapsed_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   armed_q;
	logic [COUNT_BITS-1:0]  fire_delay_q;
	logic [9:0]             pulse_rem_q;

	logic                   level;
	logic                   rising;
	logic                   falling;
	logic [COUNT_BITS-1:0]  elapsed_n;
	logic [OFFSET_BITS-1:0] offset_n;
	logic                   seen_high_n;
	logic                   armed_mid;
	logic                   armed_n;
	logic [COUNT_BITS-1:0]  fire_delay_n;
	logic                   fire;
	logic [9:0]             pulse_cur;
	logic [9:0]             pulse_rem_n;
	logic [COUNT_BITS-1:0]  delay_new;
	result_t                res;

	tpad_delay u_delay (
		.prod   (prod_q),
		.offset (offset_q),
		.delay  (delay_new)
	);

	always_comb begin
		level   = s_tdata[0];
		rising  = level && !seen_high_q;
		falling = !level && seen_high_q;

		// restart on a rising edge, otherwise advance and hold at the ceiling
		if (rising) begin
			elapsed_n = '0;
		end else if (elapsed_q != COUNT_MAX) begin
			elapsed_n = elapsed_q + COUNT_BITS'(1);
		end else begin
			elapsed_n = elapsed_q;
		end

		offset_n     = offset_q;
		seen_high_n  = seen_high_q;
		armed_mid    = armed_q;
		fire_delay_n = fire_delay_q;
		if (rising) begin
			fire_delay_n = delay_new;
			armed_mid    = 1'b1;
			seen_high_n  = 1'b1;
		end else if (falling) begin
			// the crossing center sits half the high time past the rising edge
			offset_n    = elapsed_n[COUNT_BITS-1:1];
			seen_high_n = 1'b0;
		end

		fire      = armed_mid && (elapsed_n >= fire_delay_n);
		armed_n   = fire ? 1'b0 : armed_mid;
		pulse_cur = fire ? pulse_q : pulse_rem_q;

		res.gate_drive    = (pulse_cur != '0);
		res.trigger_armed = armed_n;
		pulse_rem_n       = res.gate_drive ? pulse_cur - 10'd1 : '0;
	end

	logic s_fire;
	logic m_fire;

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_high_q  <= 1'b0;
			elapsed_q    <= '0;
			offset_q     <= '0;
			armed_q      <= 1'b0;
			fire_delay_q <= '0;
			pulse_rem_q  <= '0;
		end else if (s_fire) begin
			seen_high_q  <= seen_high_n;
			elapsed_q    <= elapsed_n;
			offset_q     <= offset_n;
			armed_q      <= armed_n;
			fire_delay_q <= fire_delay_n;
			pulse_rem_q  <= pulse_rem_n;
		end
	end

	// Two-entry result buffer: head in slot 0, overflow in slot 1.
	result_t   slot0_q;
	result_t   slot1_q;
	logic [1:0] count_q;

	assign s_tready = (count_q != 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = {6'b0, slot0_q.trigger_armed, slot0_q.gate_drive};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({s_fire, m_fire})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({s_fire, m_fire})
			2'b11: begin
				// advance the head and append
				if (count_q == 2'd1) begin
					slot0_q <= res;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= res;
				end
			end
			2'b10: begin
				if (count_q == 2'd0) begin
					slot0_q <= res;
				end else begin
					slot1_q <= res;
				end
			end
			2'b01: begin
				slot0_q <= slot1_q;
			end
			default: begin
				// hold
			end
		endcase
	end

endmodule

`default_nettype wire
